// ===== rtl/core/two_line_cache_fifo_lru_top_defines.svh =====
// Assertion helpers for the two-line cache checker.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef TWO_LINE_CACHE_FIFO_LRU_TOP_DEFINES_SVH
`define TWO_LINE_CACHE_FIFO_LRU_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define TLC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, off while reset is low.
`define TLC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/tlc_pkg.sv =====
package tlc_pkg;

    localparam int ADDR_IN_BITS  = 10;
    localparam int VALUE_BITS    = 14;
    localparam int STATUS_BITS   = 3;
    localparam int COUNT_BITS    = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // reciprocal scale for the address reduction: exact to one step below 2^ADDR_IN_BITS
    localparam int RECIP_SHIFT = 2 * ADDR_IN_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_EDIT = 2'd2;

    localparam logic [STATUS_BITS-1:0] STAT_HIT   = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_MISS  = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_EDIT  = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_LOAD  = 3'd4;

    // register index, taken from byte address bit 2
    localparam logic REG_REPLACE_MODE = 1'b0;

    typedef struct packed {
        logic [1:0]              func;
        logic [ADDR_IN_BITS-1:0] address;
        logic                    line_sel;
        logic                    word_sel;
        logic [VALUE_BITS-1:0]   value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  read_word;
        logic                   line_used;
        logic [COUNT_BITS-1:0]  hits_so_far;
        logic [COUNT_BITS-1:0]  misses_so_far;
    } t_out_item;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_cmd;

endpackage

// ===== rtl/core/tlc_mem.sv =====
module tlc_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 14,
    parameter int AW    = 10
) (
    input  logic                 i_clk,
    input  tlc_pkg::t_mem_cmd    i_cmd,
    input  logic [AW-1:0]        i_addr,
    input  logic [WIDTH-1:0]     i_wdata,
    output logic [WIDTH-1:0]     o_rdata
);
    import tlc_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (i_cmd.we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tlc_addr_mod.sv =====
module tlc_addr_mod #(
    parameter int MEM_WORDS = 1024,
    parameter int AW        = 10
) (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic [tlc_pkg::ADDR_IN_BITS-1:0] i_addr,
    output logic [AW-1:0]                    o_addr
);
    import tlc_pkg::*;

    localparam int RECIP  = (1 << RECIP_SHIFT) / MEM_WORDS;
    localparam int PROD_W = ADDR_IN_BITS + RECIP_SHIFT;

    logic [PROD_W-1:0]       prod;
    logic [ADDR_IN_BITS-1:0] r_x;
    logic [ADDR_IN_BITS-1:0] r_q;
    logic [ADDR_IN_BITS-1:0] qm;
    logic [ADDR_IN_BITS-1:0] rem_raw;
    logic [ADDR_IN_BITS-1:0] rem_fix;

    // quotient estimate, low by at most one
    assign prod = PROD_W'(i_addr) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_addr;
            r_q <= prod[RECIP_SHIFT +: ADDR_IN_BITS];
        end
    end

    assign qm      = ADDR_IN_BITS'(32'(r_q) * MEM_WORDS);
    assign rem_raw = r_x - qm;
    assign rem_fix = (32'(rem_raw) >= MEM_WORDS) ? rem_raw - ADDR_IN_BITS'(MEM_WORDS) : rem_raw;
    assign o_addr  = AW'(rem_fix);

endmodule

// ===== rtl/core/tlc_ctrl.sv =====
module tlc_ctrl #(
    parameter int MEM_WORDS = 1024,
    parameter int DATA_BITS = 14,
    parameter int AW        = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_replace_mode,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tlc_pkg::t_in_item    i_in_data,
    input  logic [AW-1:0]        i_addr,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tlc_pkg::t_out_item   o_out_data,
    output tlc_pkg::t_mem_cmd    o_mem_cmd,
    output logic [AW-1:0]        o_mem_addr,
    output logic [DATA_BITS-1:0] o_mem_wdata,
    input  logic [DATA_BITS-1:0] i_mem_rdata
);
    import tlc_pkg::*;

    localparam int BW = AW - 1;
    localparam int IW = AW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL0,
        S_FILL1
    } t_state;

    t_state                 r_state;
    t_in_item               r_req;
    logic [1:0]             r_valid;
    logic [BW-1:0]          r_block [2];
    logic [DATA_BITS-1:0]   r_even  [2];
    logic [DATA_BITS-1:0]   r_odd   [2];
    logic                   r_newest;
    logic                   r_victim;
    logic [DATA_BITS-1:0]   r_fill_even;
    logic [COUNT_BITS-1:0]  r_hits;
    logic [COUNT_BITS-1:0]  r_misses;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [COUNT_BITS-1:0]  n_hits;
    logic [COUNT_BITS-1:0]  n_misses;
    logic                   out_free;
    logic                   out_load;
    logic [BW-1:0]          blk;
    logic                   odd_word;
    logic                   hit0;
    logic                   hit1;
    logic                   hit;
    logic                   hit_line;
    logic [DATA_BITS-1:0]   hit_word;
    logic                   victim;
    logic [BW-1:0]          edit_blk;
    logic [AW-1:0]          edit_idx;
    logic                   edit_ok;

    // odd partner of the last even word wraps to word zero
    function automatic logic [AW-1:0] odd_index(input logic [BW-1:0] b);
        logic [IW-1:0]  idx;
        logic [AW-1:0]  res;
        idx = {1'b0, b, 1'b1};
        if (idx >= IW'(MEM_WORDS)) begin
            res = '0;
        end else begin
            res = idx[AW-1:0];
        end
        return res;
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign blk      = i_addr[AW-1:1];
    assign odd_word = i_addr[0];

    assign hit0     = r_valid[0] && (r_block[0] == blk);
    assign hit1     = r_valid[1] && (r_block[1] == blk);
    assign hit      = hit0 || hit1;
    assign hit_line = !hit0;
    assign hit_word = odd_word ? r_odd[hit_line] : r_even[hit_line];

    // first empty line, else the one other than r_newest: not filled last in FIFO mode, not touched last in LRU mode
    assign victim = !r_valid[0] ? 1'b0 : (!r_valid[1] ? 1'b1 : !r_newest);

    assign edit_blk = r_block[r_req.line_sel];
    assign edit_idx = r_req.word_sel ? odd_index(edit_blk) : {edit_blk, 1'b0};
    assign edit_ok  = r_valid[r_req.line_sel];

    assign n_hits   = (r_hits == COUNT_MAX) ? r_hits : r_hits + 1'b1;
    assign n_misses = (r_misses == COUNT_MAX) ? r_misses : r_misses + 1'b1;

    // a result enters the output register this cycle
    assign out_load = out_free &&
                      ((r_state == S_FILL1) ||
                       (r_state == S_EXEC && (r_req.func == FUNC_LOAD ||
                                              r_req.func == FUNC_EDIT ||
                                              (r_req.func == FUNC_READ && hit))));

    always_comb begin
        o_mem_cmd   = '0;
        o_mem_addr  = i_addr;
        o_mem_wdata = DATA_BITS'(r_req.value);
        unique case (r_state)
            S_EXEC: begin
                if (r_req.func == FUNC_LOAD && out_free) begin
                    o_mem_cmd.en = 1'b1;
                    o_mem_cmd.we = 1'b1;
                end else if (r_req.func == FUNC_READ && !hit) begin
                    o_mem_cmd.en = 1'b1;
                    o_mem_addr   = {blk, 1'b0};
                end else if (r_req.func == FUNC_EDIT && out_free && edit_ok) begin
                    o_mem_cmd.en = 1'b1;
                    o_mem_cmd.we = 1'b1;
                    o_mem_addr   = edit_idx;
                end
            end
            S_FILL0: begin
                o_mem_cmd.en = 1'b1;
                o_mem_addr   = odd_index(blk);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_newest    <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_req.func)
                        FUNC_LOAD: begin
                            if (out_free) begin
                                r_out   <= '{STAT_LOAD, '0, 1'b0, r_hits, r_misses};
                                r_state <= S_IDLE;
                            end
                        end
                        FUNC_READ: begin
                            if (!hit) begin
                                r_victim <= victim;
                                r_state  <= S_FILL0;
                            end else if (out_free) begin
                                r_hits <= n_hits;
                                if (i_replace_mode) begin
                                    r_newest <= hit_line;
                                end
                                r_out <= '{STAT_HIT, VALUE_BITS'(hit_word), hit_line,
                                           n_hits, r_misses};
                                r_state <= S_IDLE;
                            end
                        end
                        FUNC_EDIT: begin
                            if (out_free) begin
                                if (edit_ok) begin
                                    if (r_req.word_sel) begin
                                        r_odd[r_req.line_sel] <= DATA_BITS'(r_req.value);
                                    end else begin
                                        r_even[r_req.line_sel] <= DATA_BITS'(r_req.value);
                                    end
                                    r_out <= '{STAT_EDIT, '0, r_req.line_sel, r_hits, r_misses};
                                end else begin
                                    r_out <= '{STAT_EMPTY, '0, r_req.line_sel, r_hits, r_misses};
                                end
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            // drop the unused code without a result
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_FILL0: begin
                    r_fill_even <= i_mem_rdata;
                    r_state     <= S_FILL1;
                end
                S_FILL1: begin
                    if (out_free) begin
                        r_valid[r_victim] <= 1'b1;
                        r_block[r_victim] <= blk;
                        r_even[r_victim]  <= r_fill_even;
                        r_odd[r_victim]   <= i_mem_rdata;
                        r_newest          <= r_victim;
                        r_misses          <= n_misses;
                        r_out <= '{STAT_MISS,
                                   VALUE_BITS'(odd_word ? i_mem_rdata : r_fill_even),
                                   r_victim, r_hits, n_misses};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/two_line_cache_fifo_lru_top.sv =====
// Two-line fully associative cache of two-word blocks in front of a main memory
// of MEM_WORDS words held inside the block, one request at a time. A load, an
// edit or a read hit registers its result in state S_EXEC once the output
// register is free, and the next request is taken back in S_IDLE; a read miss
// registers its result in S_FILL1, after S_EXEC and S_FILL0, since the even and
// odd words of the block are read one after the other from the single-port main
// memory. A result waiting in the output register does not hold back the next
// request; a new one waits only when it would need that register. Addresses are
// reduced modulo MEM_WORDS in the cycle after acceptance. There is no clearing
// pass: main memory words read before they are ever loaded or edited are
// undefined. Register 0 at byte 0: bit 0 selects the replacement policy, 0 first
// in first out, 1 least recently used.
module two_line_cache_fifo_lru_top #(
    parameter int MEM_WORDS = 1024,
    parameter int DATA_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tlc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tlc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tlc_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tlc_pkg::t_out_item                 o_out_data
);
    import tlc_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    logic                 r_replace_mode;
    logic                 in_accept;
    logic [AW-1:0]        red_addr;
    t_mem_cmd             mem_cmd;
    logic [AW-1:0]        mem_addr;
    logic [DATA_BITS-1:0] mem_wdata;
    logic [DATA_BITS-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_REPLACE_MODE) begin
            r_replace_mode <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_REPLACE_MODE) ? APB_DATA_BITS'(r_replace_mode) : '0;
    assign pready = 1'b1;

    assign in_accept = i_in_valid && !o_in_stall;

    tlc_addr_mod #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_addr_mod (
        .i_clk  (i_clk),
        .i_load (in_accept),
        .i_addr (i_in_data.address),
        .o_addr (red_addr)
    );

    tlc_ctrl #(
        .MEM_WORDS (MEM_WORDS),
        .DATA_BITS (DATA_BITS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_replace_mode (r_replace_mode),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_addr         (red_addr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data),
        .o_mem_cmd      (mem_cmd),
        .o_mem_addr     (mem_addr),
        .o_mem_wdata    (mem_wdata),
        .i_mem_rdata    (mem_rdata)
    );

    tlc_mem #(
        .DEPTH (MEM_WORDS),
        .WIDTH (DATA_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== rtl/core/tlc_checker.sv =====
`include "two_line_cache_fifo_lru_top_defines.svh"

module tlc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tlc_pkg::t_out_item o_out_data
);
    import tlc_pkg::*;

    logic no_word_status;
    logic hit_out;

    assign no_word_status = o_out_data.status == STAT_LOAD ||
                            o_out_data.status == STAT_EDIT ||
                            o_out_data.status == STAT_EMPTY;
    assign hit_out        = o_out_valid && o_out_data.status == STAT_HIT;

    // one request in flight: the cycle after acceptance stalls the input
    `TLC_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)

    // only reads return a word
    `TLC_ASSERT_IMPL(a_no_word_off_read, o_out_valid && no_word_status, o_out_data.read_word == '0)

    // a hit result counts itself
    `TLC_ASSERT_IMPL(a_hit_counted, hit_out, o_out_data.hits_so_far != '0)

    // stalled result holds
    `TLC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind two_line_cache_fifo_lru_top tlc_checker u_checker (.*);
